// ===== design/stbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stbe_pkg;

  // Configuration register map, one 32-bit word per register.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COEF_W = 16;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_LOW_POLE  = 3'd0;
  localparam reg_idx_t REG_HIGH_POLE = 3'd1;
  localparam reg_idx_t REG_LOW_GAIN  = 3'd2;
  localparam reg_idx_t REG_HIGH_GAIN = 3'd3;
  localparam reg_idx_t REG_OUT_GAIN  = 3'd4;

  localparam logic [COEF_W-1:0] LOW_POLE_RST  = 16'd63985;
  localparam logic [COEF_W-1:0] HIGH_POLE_RST = 16'd48812;
  localparam logic [COEF_W-1:0] LOW_GAIN_RST  = 16'd6936;
  localparam logic [COEF_W-1:0] HIGH_GAIN_RST = 16'd6936;
  localparam logic [COEF_W-1:0] OUT_GAIN_RST  = 16'd2898;

  // Smoother state carries this many fraction bits beyond the sample.
  localparam int unsigned EXTRA_FRAC = 8;

  typedef struct packed {
    logic [COEF_W-1:0] low_pole;
    logic [COEF_W-1:0] high_pole;
    logic [COEF_W-1:0] low_gain;
    logic [COEF_W-1:0] high_gain;
    logic [COEF_W-1:0] out_gain;
  } coef_t;

endpackage

`default_nettype wire

// ===== design/stereo_three_band_enhancer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A single shared multiplier runs five products per channel over a 7-step
// sequence, left channel then right. A new stereo word is accepted only after
// the previous result has been loaded into the output register.
// Reset (synchronous, active high) clears the smoothers and the handshake state
// and loads the default poles and gains.
module stereo_three_band_enhancer #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [stbe_pkg::ADDR_W-1:0]     paddr,
  input  wire  [stbe_pkg::DATA_W-1:0]     pwdata,
  output logic [stbe_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  signed [SAMPLE_WIDTH-1:0]  left_sample,
  input  wire  signed [SAMPLE_WIDTH-1:0]  right_sample,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  left_out,
  output logic signed [SAMPLE_WIDTH-1:0]  right_out
);
  import stbe_pkg::*;

  localparam int W   = SAMPLE_WIDTH;
  localparam int SW  = W + EXTRA_FRAC;     // smoother state
  localparam int AW  = SW + 8;             // multiplier data operand
  localparam int BW  = COEF_W + 1;         // multiplier coefficient operand
  localparam int PW  = AW + BW;            // product
  localparam int ACW = SW + 19;            // band mix accumulator
  localparam int YW  = PW - 20;            // output before clipping

  localparam logic signed [PW-1:0]  RND16   = {{(PW-16){1'b0}}, 16'h8000};
  localparam logic signed [PW-1:0]  RND20   = {{(PW-20){1'b0}}, 20'h80000};
  localparam logic signed [ACW-1:0] ACC_RND = {{(ACW-12){1'b0}}, 12'h800};
  localparam logic signed [YW-1:0]  Y_MAX   = {{(YW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [YW-1:0]  Y_MIN   = {{(YW-W+1){1'b1}}, {(W-1){1'b0}}};

  localparam logic [2:0] STEP_LO_MUL = 3'd0;
  localparam logic [2:0] STEP_HI_MUL = 3'd1;
  localparam logic [2:0] STEP_LG_MUL = 3'd2;
  localparam logic [2:0] STEP_HG_MUL = 3'd3;
  localparam logic [2:0] STEP_HG_ACC = 3'd4;
  localparam logic [2:0] STEP_OG_MUL = 3'd5;
  localparam logic [2:0] STEP_OUT    = 3'd6;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

  state_t   state;
  logic [2:0] step;
  logic     ch;
  coef_t    coef;

  logic signed [W-1:0]   lsamp, rsamp;
  logic signed [SW-1:0]  lo_st [2];
  logic signed [SW-1:0]  hi_st [2];
  logic signed [PW-1:0]  prod;
  logic signed [ACW-1:0] acc;
  logic signed [W-1:0]   res_l;
  logic signed [W-1:0]   y_sat_r;

  logic signed [W-1:0]    x_cur;
  logic signed [SW-1:0]   x8;
  logic signed [SW-1:0]   lo_cur, hi_cur;
  logic signed [SW:0]     diff_lo, diff_hi, hi_band, mid_band;
  logic signed [ACW-13:0] mix_m;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [PW-1:0]   prod_r16, prod_r20;
  logic signed [SW:0]     smooth_new;
  logic signed [YW-1:0]   y_full;
  logic signed [W-1:0]    y_sat;
  logic                   cfg_wr, in_fire, out_load;
  reg_idx_t               cfg_idx;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.low_pole  <= LOW_POLE_RST;
      coef.high_pole <= HIGH_POLE_RST;
      coef.low_gain  <= LOW_GAIN_RST;
      coef.high_gain <= HIGH_GAIN_RST;
      coef.out_gain  <= OUT_GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LOW_POLE:  coef.low_pole  <= pwdata[COEF_W-1:0];
        REG_HIGH_POLE: coef.high_pole <= pwdata[COEF_W-1:0];
        REG_LOW_GAIN:  coef.low_gain  <= pwdata[COEF_W-1:0];
        REG_HIGH_GAIN: coef.high_gain <= pwdata[COEF_W-1:0];
        REG_OUT_GAIN:  coef.out_gain  <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LOW_POLE:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef.low_pole};
      REG_HIGH_POLE: prdata = {{(DATA_W-COEF_W){1'b0}}, coef.high_pole};
      REG_LOW_GAIN:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef.low_gain};
      REG_HIGH_GAIN: prdata = {{(DATA_W-COEF_W){1'b0}}, coef.high_gain};
      REG_OUT_GAIN:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef.out_gain};
      default:       prdata = '0;
    endcase
  end

  // Datapath around the shared multiplier.
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  assign x_cur  = ch ? rsamp : lsamp;
  assign x8     = {x_cur, {EXTRA_FRAC{1'b0}}};
  assign lo_cur = lo_st[ch];
  assign hi_cur = hi_st[ch];

  assign diff_lo  = {lo_cur[SW-1], lo_cur} - {x8[SW-1], x8};
  assign diff_hi  = {hi_cur[SW-1], hi_cur} - {x8[SW-1], x8};
  assign hi_band  = {x8[SW-1], x8} - {hi_cur[SW-1], hi_cur};
  assign mid_band = {hi_cur[SW-1], hi_cur} - {lo_cur[SW-1], lo_cur};
  assign mix_m    = acc[ACW-1:12];

  always_comb begin
    unique case (step)
      STEP_LO_MUL: begin
        mul_a = AW'(diff_lo);
        mul_b = {1'b0, coef.low_pole};
      end
      STEP_HI_MUL: begin
        mul_a = AW'(diff_hi);
        mul_b = {1'b0, coef.high_pole};
      end
      STEP_LG_MUL: begin
        mul_a = AW'(lo_cur);
        mul_b = {1'b0, coef.low_gain};
      end
      STEP_HG_MUL: begin
        mul_a = AW'(hi_band);
        mul_b = {1'b0, coef.high_gain};
      end
      STEP_OG_MUL: begin
        mul_a = AW'(mix_m);
        mul_b = {1'b0, coef.out_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // The smoother update is x8 + round(p * (state - x8)); this is exact mod 2^(SW+1).
  assign prod_r16   = prod + RND16;
  assign smooth_new = {x8[SW-1], x8} + prod_r16[SW+16:16];

  assign prod_r20 = prod + RND20;
  assign y_full   = prod_r20[PW-1:20];

  always_comb begin
    if (y_full > Y_MAX) begin
      y_sat = Y_MAX[W-1:0];
    end else if (y_full < Y_MIN) begin
      y_sat = Y_MIN[W-1:0];
    end else begin
      y_sat = y_full[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lsamp <= left_sample;
      rsamp <= right_sample;
    end
    prod <= mul_p;
    if (state == ST_RUN) begin
      if (step == STEP_HG_MUL) begin
        acc <= prod[ACW-1:0] + (ACW'(mid_band) <<< 12) + ACC_RND;
      end else if (step == STEP_HG_ACC) begin
        acc <= acc + prod[ACW-1:0];
      end
      if (step == STEP_OUT && !ch) begin
        res_l <= y_sat;
      end
    end
    if (out_load) begin
      left_out  <= res_l;
      right_out <= y_sat_r;
    end
  end

  // Right result is held until the output slot frees up.
  always_ff @(posedge clk) begin
    if (state == ST_RUN && step == STEP_OUT && ch) begin
      y_sat_r <= y_sat;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_LO_MUL;
      ch        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        lo_st[i] <= '0;
        hi_st[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          step <= STEP_LO_MUL;
          ch   <= 1'b0;
          if (in_fire) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step == STEP_HI_MUL) begin
            lo_st[ch] <= smooth_new[SW-1:0];
          end
          if (step == STEP_LG_MUL) begin
            hi_st[ch] <= smooth_new[SW-1:0];
          end
          if (step == STEP_OUT) begin
            step <= STEP_LO_MUL;
            ch   <= ~ch;
            if (ch) begin
              state <= ST_FINISH;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("block ready right after accepting a word");

  a_idle_sequencer: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step == STEP_LO_MUL && !ch))
    else $error("sequencer not parked while idle");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("finished word not handed to the output register");

  a_smoothers_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state == ST_IDLE))
      |-> ($stable(lo_st[0]) && $stable(hi_st[1])))
    else $error("smoother state changed while idle");

endmodule

`default_nettype wire
